/* sv/ffca_pkg.sv */
`timescale 1ns / 1ps

package ffca_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

    localparam int OUT_RDATA_LSB = 0;
    localparam int OUT_FOUND_BIT = 32;
    localparam int OUT_ALLOC_LSB = 33;
    localparam int OUT_ALLOC_MSB = 42;
    localparam int OUT_FREE_LSB  = 43;
    localparam int OUT_FREE_MSB  = 74;

    localparam int          FIRST_DATA_CLUSTER = 2;
    localparam logic [31:0] HINT_UNKNOWN       = 32'hFFFF_FFFF;
    localparam logic [31:0] COUNT_UNKNOWN      = 32'hFFFF_FFFF;
    localparam logic [31:0] END_OF_CHAIN_MARK  = 32'h0FFF_FFFF;
    localparam logic [10:0] TOTAL_ENTRIES_RST  = 11'd1024;

    localparam logic [0:0] REG_TOTAL_ENTRIES = 1'b0;

    typedef enum logic [2:0] {
        OP_WRITE     = 3'd0,
        OP_READ      = 3'd1,
        OP_ALLOC     = 3'd2,
        OP_SET_HINT  = 3'd3,
        OP_SET_COUNT = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_LINK,
        ST_MARK,
        ST_DONE
    } state_t;

endpackage

/* sv/ffca_ram.sv */
`timescale 1ns / 1ps

module ffca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/fat_free_cluster_allocator_core.sv */
`timescale 1ns / 1ps

// Cluster allocation table with next-free hint and free count, one item in flight at a time.
// The table sits in a single-port RAM with registered read; every access goes through that one
// port. Write entry, set hint and set count go from idle straight to the done state, read
// entry through the read state; the done state raises m_tvalid. Allocate reads one table entry
// per cycle, starting at the hint and wrapping from the bound (min of total_entries and
// TABLE_DEPTH) back to cluster 2. A find then passes the link and mark states, one RAM access
// each for the link and end-of-chain writes, before the done state. A bound of 2 or less
// answers like a write. If the previous result still waits in the output register, the done
// state waits until it is taken. A finished result waits in the output register while the next
// item is accepted.
module fat_free_cluster_allocator_core #(
    parameter int TABLE_DEPTH = ffca_pkg::TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] operation, [12:3] entry_index, [44:13] entry_value, [45] link_previous
    input  logic [47:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] read_data, [32] found, [42:33] allocated_cluster, [74:43] remaining_free
    output logic [79:0] m_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = AW + 1;

    ffca_pkg::state_t state_reg, state_next;

    logic [10:0]   te_reg;
    logic [31:0]   hint_reg, hint_next;
    logic [31:0]   count_reg, count_next;
    logic [9:0]    idx_reg, idx_next;
    logic          link_reg, link_next;
    logic [SW-1:0] start_reg, start_next;
    logic [SW-1:0] issue_idx_reg, issue_idx_next;
    logic          wrapped_reg, wrapped_next;
    logic          issue_done_reg, issue_done_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [SW-1:0] rd_idx_reg, rd_idx_next;
    logic [SW-1:0] found_idx_reg, found_idx_next;
    logic [31:0]   res_rdata_reg, res_rdata_next;
    logic          res_found_reg, res_found_next;
    logic [9:0]    res_alloc_reg, res_alloc_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [79:0]   m_tdata_reg, m_tdata_next;

    logic          mem_en, mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata, mem_rdata;

    ffca_pkg::op_t in_op;
    logic [9:0]    in_idx;
    logic [31:0]   in_val;
    logic          in_link;
    logic          in_idx_ok, reg_idx_ok;
    logic [SW-1:0] bound_c, start_c, nxt_c, nxt_wrap_c;
    logic          wrap_now_c, cfg_wr;

    assign in_op   = ffca_pkg::op_t'(s_tdata[2:0]);
    assign in_idx  = s_tdata[12:3];
    assign in_val  = s_tdata[44:13];
    assign in_link = s_tdata[45];

    assign in_idx_ok  = {22'd0, in_idx} < 32'(TABLE_DEPTH);
    assign reg_idx_ok = {22'd0, idx_reg} < 32'(TABLE_DEPTH);

    assign bound_c = ({21'd0, te_reg} > 32'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : SW'(te_reg);

    always_comb begin
        if (hint_reg == ffca_pkg::HINT_UNKNOWN ||
            hint_reg < 32'(ffca_pkg::FIRST_DATA_CLUSTER)) begin
            start_c = SW'(ffca_pkg::FIRST_DATA_CLUSTER);
        end else if (hint_reg >= 32'(bound_c)) begin
            start_c = bound_c;
        end else begin
            start_c = SW'(hint_reg);
        end
    end

    assign nxt_c      = issue_idx_reg + SW'(1);
    assign wrap_now_c = !wrapped_reg && (nxt_c == bound_c);
    assign nxt_wrap_c = wrap_now_c ? SW'(ffca_pkg::FIRST_DATA_CLUSTER) : nxt_c;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ffca_pkg::REG_TOTAL_ENTRIES);
    assign prdata = (paddr[2] == ffca_pkg::REG_TOTAL_ENTRIES) ? {21'd0, te_reg} : 32'd0;

    assign s_tready = (state_reg == ffca_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next      = state_reg;
        hint_next       = hint_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        link_next       = link_reg;
        start_next      = start_reg;
        issue_idx_next  = issue_idx_reg;
        wrapped_next    = wrapped_reg;
        issue_done_next = issue_done_reg;
        rd_vld_next     = rd_vld_reg;
        rd_idx_next     = rd_idx_reg;
        found_idx_next  = found_idx_reg;
        res_rdata_next  = res_rdata_reg;
        res_found_next  = res_found_reg;
        res_alloc_next  = res_alloc_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        mem_en          = 1'b0;
        mem_we          = 1'b0;
        mem_addr        = AW'(in_idx);
        mem_wdata       = in_val;

        unique case (state_reg)
            ffca_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    idx_next       = in_idx;
                    link_next      = in_link;
                    res_rdata_next = 32'd0;
                    res_found_next = 1'b0;
                    res_alloc_next = 10'd0;
                    state_next     = ffca_pkg::ST_DONE;
                    unique case (in_op)
                        ffca_pkg::OP_WRITE: begin
                            if (in_idx_ok) begin
                                mem_en = 1'b1;
                                mem_we = 1'b1;
                            end
                        end
                        ffca_pkg::OP_READ: begin
                            if (in_idx_ok) begin
                                mem_en     = 1'b1;
                                state_next = ffca_pkg::ST_READ;
                            end
                        end
                        ffca_pkg::OP_ALLOC: begin
                            if (bound_c > SW'(ffca_pkg::FIRST_DATA_CLUSTER)) begin
                                start_next      = start_c;
                                issue_done_next = 1'b0;
                                rd_vld_next     = 1'b0;
                                state_next      = ffca_pkg::ST_SCAN;
                                if (start_c == bound_c) begin
                                    issue_idx_next = SW'(ffca_pkg::FIRST_DATA_CLUSTER);
                                    wrapped_next   = 1'b1;
                                end else begin
                                    issue_idx_next = start_c;
                                    wrapped_next   = 1'b0;
                                end
                            end
                        end
                        ffca_pkg::OP_SET_HINT:  hint_next  = in_val;
                        ffca_pkg::OP_SET_COUNT: count_next = in_val;
                        default: ;
                    endcase
                end
            end
            ffca_pkg::ST_READ: begin
                res_rdata_next = mem_rdata;
                state_next     = ffca_pkg::ST_DONE;
            end
            ffca_pkg::ST_SCAN: begin
                if (rd_vld_reg && mem_rdata == 32'd0) begin
                    found_idx_next = rd_idx_reg;
                    rd_vld_next    = 1'b0;
                    state_next     = ffca_pkg::ST_LINK;
                end else if (issue_done_reg) begin
                    rd_vld_next = 1'b0;
                    if (!rd_vld_reg) begin
                        state_next = ffca_pkg::ST_DONE;
                    end
                end else begin
                    mem_en          = 1'b1;
                    mem_addr        = issue_idx_reg[AW-1:0];
                    rd_vld_next     = 1'b1;
                    rd_idx_next     = issue_idx_reg;
                    issue_idx_next  = nxt_wrap_c;
                    wrapped_next    = wrapped_reg || wrap_now_c;
                    issue_done_next = (wrapped_reg || wrap_now_c) && (nxt_wrap_c >= start_reg);
                end
            end
            ffca_pkg::ST_LINK: begin
                // link first so the end-of-chain mark wins on a self link
                if (link_reg && reg_idx_ok) begin
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_addr  = AW'(idx_reg);
                    mem_wdata = 32'(found_idx_reg);
                end
                state_next = ffca_pkg::ST_MARK;
            end
            ffca_pkg::ST_MARK: begin
                mem_en         = 1'b1;
                mem_we         = 1'b1;
                mem_addr       = found_idx_reg[AW-1:0];
                mem_wdata      = ffca_pkg::END_OF_CHAIN_MARK;
                hint_next      = 32'(found_idx_reg);
                res_found_next = 1'b1;
                res_alloc_next = 10'(found_idx_reg);
                if (count_reg != 32'd0 && count_reg != ffca_pkg::COUNT_UNKNOWN) begin
                    count_next = count_reg - 32'd1;
                end
                state_next = ffca_pkg::ST_DONE;
            end
            ffca_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, count_reg, res_alloc_reg, res_found_reg,
                                     res_rdata_reg};
                    state_next    = ffca_pkg::ST_IDLE;
                end
            end
            default: state_next = ffca_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ffca_pkg::ST_IDLE;
            te_reg         <= ffca_pkg::TOTAL_ENTRIES_RST;
            hint_reg       <= ffca_pkg::HINT_UNKNOWN;
            count_reg      <= 32'd0;
            wrapped_reg    <= 1'b0;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hint_reg       <= hint_next;
            count_reg      <= count_next;
            wrapped_reg    <= wrapped_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_wr) begin
                te_reg <= pwdata[10:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        link_reg      <= link_next;
        start_reg     <= start_next;
        issue_idx_reg <= issue_idx_next;
        rd_idx_reg    <= rd_idx_next;
        found_idx_reg <= found_idx_next;
        res_rdata_reg <= res_rdata_next;
        res_found_reg <= res_found_next;
        res_alloc_reg <= res_alloc_next;
        m_tdata_reg   <= m_tdata_next;
    end

    ffca_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

/* sv/ffca_checker.sv */
`timescale 1ns / 1ps

module ffca_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    logic        out_found;
    logic [9:0]  out_alloc;
    logic [31:0] out_rdata;

    assign out_found = m_tdata[ffca_pkg::OUT_FOUND_BIT];
    assign out_alloc = m_tdata[ffca_pkg::OUT_ALLOC_MSB:ffca_pkg::OUT_ALLOC_LSB];
    assign out_rdata = m_tdata[ffca_pkg::OUT_RDATA_LSB +: 32];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !out_found |-> out_alloc == 10'd0)
        else $error("cluster reported without a find");

    a_hit_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_found |-> out_rdata == 32'd0 &&
            out_alloc >= 10'(ffca_pkg::FIRST_DATA_CLUSTER))
        else $error("allocate result malformed");

endmodule

bind fat_free_cluster_allocator_core ffca_checker u_ffca_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
